// ===== sv/merge_sorter_core_defines.svh =====
// Assertion macros shared by the merge sorter RTL.
// Used by merge_sorter_core; expects aclk and aresetn in scope.
`ifndef MERGE_SORTER_CORE_DEFINES_SVH
`define MERGE_SORTER_CORE_DEFINES_SVH

// same-cycle implication
`define MSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MSC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/msort_pkg.sv =====
// Shared types and constants of the merge sorter.
// No dependencies.
package msort_pkg;

    localparam int DATA_W = 32;

    typedef logic signed [DATA_W-1:0] value_t;

    typedef struct packed {
        logic done;     // one-cycle pulse, sort finished
        logic res_sel;  // memory that holds the sorted set (0: mem0, 1: mem1)
    } merge_stat_t;

endpackage

// ===== sv/msort_ram.sv =====
// Generic simple RAM: one write port, two registered read ports.
// No dependencies.
module msort_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a <= mem_reg[raddr_a];
        rdata_b <= mem_reg[raddr_b];
    end

endmodule

// ===== sv/msort_merge.sv =====
// Bottom-up merge sequencer: ping-pong passes between two RAMs, one write per cycle while merging (none in M_SETUP).
// Depends on msort_pkg; drives the read and write ports of two msort_ram instances.
module msort_merge #(
    parameter int MAX_COUNT = 64
) (
    input  logic                          clk,
    input  logic                          rstn,
    input  logic                          start,
    input  logic [$clog2(MAX_COUNT+1)-1:0] n_in,
    output logic [$clog2(MAX_COUNT)-1:0]   rd_addr_a,
    output logic [$clog2(MAX_COUNT)-1:0]   rd_addr_b,
    input  msort_pkg::value_t              rd_data_a,
    input  msort_pkg::value_t              rd_data_b,
    output logic                          wr_en,
    output logic [$clog2(MAX_COUNT)-1:0]   wr_addr,
    output msort_pkg::value_t              wr_data,
    output msort_pkg::merge_stat_t         stat
);

    localparam int AW = $clog2(MAX_COUNT);
    localparam int CW = $clog2(MAX_COUNT + 1);
    localparam int SW = CW + 2;

    typedef enum logic [1:0] {
        M_IDLE,
        M_SETUP,
        M_MERGE
    } mstate_t;

    mstate_t           state_reg;
    logic              done_reg;
    logic              src_reg;
    logic              fresh_l_reg;
    logic              fresh_r_reg;
    logic [CW-1:0]     n_reg;
    logic [CW-1:0]     w_reg;
    logic [CW-1:0]     lo_reg;
    logic [CW-1:0]     mid_reg;
    logic [CW-1:0]     hi_reg;
    logic [CW-1:0]     i_reg;
    logic [CW-1:0]     j_reg;
    logic [CW-1:0]     k_reg;
    msort_pkg::value_t hl_reg;
    msort_pkg::value_t hr_reg;

    msort_pkg::value_t hl;
    msort_pkg::value_t hr;
    logic              l_ok;
    logic              r_ok;
    logic              take_l;
    logic [CW-1:0]     k_next;
    logic              pair_end;
    logic [SW-1:0]     n_s;
    logic [SW-1:0]     w2_s;
    logic [SW-1:0]     lo_next_s;
    logic [SW-1:0]     mid_next_s;
    logic [SW-1:0]     hi_next_s;
    logic [SW-1:0]     phi_s;
    logic [CW-1:0]     mid_next;
    logic [CW-1:0]     hi_next;
    logic [CW-1:0]     phi;

    always_comb begin
        hl     = fresh_l_reg ? rd_data_a : hl_reg;
        hr     = fresh_r_reg ? rd_data_b : hr_reg;
        l_ok   = i_reg < mid_reg;
        r_ok   = j_reg < hi_reg;
        take_l = l_ok && (!r_ok || (hl < hr));

        k_next   = k_reg + 1'b1;
        pair_end = (k_next == hi_reg);

        n_s        = SW'(n_reg);
        w2_s       = SW'(w_reg) << 1;
        lo_next_s  = SW'(lo_reg) + w2_s;
        mid_next_s = lo_next_s + SW'(w_reg);
        hi_next_s  = lo_next_s + w2_s;
        phi_s      = w2_s << 1;
        mid_next   = (mid_next_s < n_s) ? mid_next_s[CW-1:0] : n_reg;
        hi_next    = (hi_next_s < n_s) ? hi_next_s[CW-1:0] : n_reg;
        phi        = (phi_s < n_s) ? phi_s[CW-1:0] : n_reg;

        if (state_reg == M_MERGE) begin
            rd_addr_a = AW'(i_reg + 1'b1);
            rd_addr_b = AW'(j_reg + 1'b1);
        end else begin
            rd_addr_a = AW'(i_reg);
            rd_addr_b = AW'(j_reg);
        end

        wr_en   = (state_reg == M_MERGE);
        wr_addr = AW'(k_reg);
        wr_data = take_l ? hl : hr;

        stat.done    = done_reg;
        stat.res_sel = src_reg;
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            state_reg   <= M_IDLE;
            done_reg    <= 1'b0;
            src_reg     <= 1'b0;
            fresh_l_reg <= 1'b0;
            fresh_r_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                M_IDLE: begin
                    if (start) begin
                        n_reg   <= n_in;
                        src_reg <= 1'b0;
                        w_reg   <= CW'(1);
                        lo_reg  <= '0;
                        mid_reg <= CW'(1);
                        hi_reg  <= CW'(2);
                        i_reg   <= '0;
                        j_reg   <= CW'(1);
                        k_reg   <= '0;
                        if (n_in < CW'(2)) begin
                            done_reg <= 1'b1;
                        end else begin
                            state_reg <= M_SETUP;
                        end
                    end
                end
                M_SETUP: begin
                    fresh_l_reg <= 1'b1;
                    fresh_r_reg <= 1'b1;
                    state_reg   <= M_MERGE;
                end
                M_MERGE: begin
                    hl_reg      <= hl;
                    hr_reg      <= hr;
                    k_reg       <= k_next;
                    fresh_l_reg <= take_l;
                    fresh_r_reg <= !take_l;
                    if (take_l) begin
                        i_reg <= i_reg + 1'b1;
                    end else begin
                        j_reg <= j_reg + 1'b1;
                    end
                    if (pair_end) begin
                        if (lo_next_s < n_s) begin
                            lo_reg    <= lo_next_s[CW-1:0];
                            mid_reg   <= mid_next;
                            hi_reg    <= hi_next;
                            i_reg     <= lo_next_s[CW-1:0];
                            j_reg     <= mid_next;
                            k_reg     <= lo_next_s[CW-1:0];
                            state_reg <= M_SETUP;
                        end else begin
                            src_reg <= !src_reg;
                            if (w2_s >= n_s) begin
                                done_reg  <= 1'b1;
                                state_reg <= M_IDLE;
                            end else begin
                                w_reg     <= w2_s[CW-1:0];
                                lo_reg    <= '0;
                                mid_reg   <= w2_s[CW-1:0];
                                hi_reg    <= phi;
                                i_reg     <= '0;
                                j_reg     <= w2_s[CW-1:0];
                                k_reg     <= '0;
                                state_reg <= M_SETUP;
                            end
                        end
                    end
                end
                default: begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== sv/msort_obuf.sv =====
// Output register plus skid stage for the sorted stream, fed by RAM reads.
// Depends on msort_pkg; tracks one read in flight to keep credit with two slots.
module msort_obuf (
    input  logic              clk,
    input  logic              rstn,
    input  logic              issue,
    input  logic              issue_last,
    input  msort_pkg::value_t rd_data,
    output logic              room,
    output logic              empty,
    output logic              m_tvalid,
    input  logic              m_tready,
    output msort_pkg::value_t m_tdata,
    output logic              m_tlast
);

    logic              out_v_reg;
    logic              skid_v_reg;
    logic              infl_reg;
    logic              infl_last_reg;
    msort_pkg::value_t out_data_reg;
    logic              out_last_reg;
    msort_pkg::value_t skid_data_reg;
    logic              skid_last_reg;

    logic              pop;
    logic [1:0]        occ;
    logic [1:0]        occ_left;
    logic              load_out;

    always_comb begin
        pop      = out_v_reg && m_tready;
        occ      = 2'(out_v_reg) + 2'(skid_v_reg) + 2'(infl_reg);
        occ_left = occ - 2'(pop);
        room     = occ_left < 2'd2;
        empty    = (occ == 2'd0);
        load_out = !out_v_reg || pop;
        m_tvalid = out_v_reg;
        m_tdata  = out_data_reg;
        m_tlast  = out_last_reg;
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
            infl_reg   <= 1'b0;
        end else begin
            infl_reg <= issue;
            if (load_out) begin
                out_v_reg  <= skid_v_reg || infl_reg;
                skid_v_reg <= skid_v_reg && infl_reg;
            end else if (infl_reg) begin
                skid_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk) begin
        infl_last_reg <= issue_last;
        if (load_out) begin
            if (skid_v_reg) begin
                out_data_reg <= skid_data_reg;
                out_last_reg <= skid_last_reg;
                if (infl_reg) begin
                    skid_data_reg <= rd_data;
                    skid_last_reg <= infl_last_reg;
                end
            end else if (infl_reg) begin
                out_data_reg <= rd_data;
                out_last_reg <= infl_last_reg;
            end
        end else if (infl_reg) begin
            skid_data_reg <= rd_data;
            skid_last_reg <= infl_last_reg;
        end
    end

endmodule

// ===== sv/merge_sorter_core.sv =====
// Merge sorter top level: load, bottom-up merge sort in two RAMs, sorted emission.
// Depends on msort_pkg, msort_ram, msort_merge, msort_obuf, merge_sorter_core_defines.svh.
//
//  channel  | ports                        | contents
//  ---------+------------------------------+----------------------------------------
//  input    | s_tvalid/s_tready/s_tdata/.. | tdata: value; tlast: last_in
//  result   | m_tvalid/m_tready/m_tdata/.. | tdata: sorted_value; tlast: last_out;
//           |                              | tuser: overflow
//
// Load: one transaction per cycle while s_tready is high.
// Sort: ceil(log2(n)) passes, one RAM write per cycle while merging, with a setup state before each run pair.
// Emission: one transaction per cycle while m_tready is high, through the registered RAM read and a two-slot skid.
// s_tready is low from the tlast transaction until the last result is taken.
// Reset is synchronous; no RAM clearing pass.
`include "merge_sorter_core_defines.svh"

module merge_sorter_core #(
    parameter int MAX_COUNT = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] sorted_value
    output logic        m_tlast,
    output logic        m_tuser    // [0] overflow
);

    localparam int AW = $clog2(MAX_COUNT);
    localparam int CW = $clog2(MAX_COUNT + 1);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_EMIT
    } state_t;

    state_t                 state_reg;
    logic [CW-1:0]          count_reg;
    logic                   dropped_reg;
    logic [CW-1:0]          emit_reg;

    logic                   s_accept;
    logic                   has_room;
    logic                   load_we;
    logic [CW-1:0]          count_next;

    logic [AW-1:0]          mg_rd_addr_a;
    logic [AW-1:0]          mg_rd_addr_b;
    logic                   mg_wr_en;
    logic [AW-1:0]          mg_wr_addr;
    msort_pkg::value_t      mg_wr_data;
    msort_pkg::merge_stat_t mg_stat;

    logic [AW-1:0]          rd_addr_a;
    logic [AW-1:0]          rd_addr_b;
    logic                   m0_we;
    logic [AW-1:0]          m0_waddr;
    msort_pkg::value_t      m0_wdata;
    logic                   m1_we;
    msort_pkg::value_t      m0_rdata_a;
    msort_pkg::value_t      m0_rdata_b;
    msort_pkg::value_t      m1_rdata_a;
    msort_pkg::value_t      m1_rdata_b;
    msort_pkg::value_t      src_data_a;
    msort_pkg::value_t      src_data_b;

    logic                   emit_issue;
    logic                   emit_last;
    logic                   ob_room;
    logic                   ob_empty;
    msort_pkg::value_t      ob_tdata;

    always_comb begin
        s_tready   = (state_reg == ST_LOAD);
        s_accept   = s_tvalid && s_tready;
        has_room   = count_reg < CW'(MAX_COUNT);
        load_we    = s_accept && has_room;
        count_next = count_reg + CW'(has_room);

        emit_issue = (state_reg == ST_EMIT) && (emit_reg < count_reg) && ob_room;
        emit_last  = (CW'(emit_reg + 1'b1) == count_reg);

        if (state_reg == ST_EMIT) begin
            rd_addr_a = AW'(emit_reg);
        end else begin
            rd_addr_a = mg_rd_addr_a;
        end
        rd_addr_b = mg_rd_addr_b;

        m0_we    = load_we || (mg_wr_en && mg_stat.res_sel);
        m0_waddr = load_we ? AW'(count_reg) : mg_wr_addr;
        m0_wdata = load_we ? msort_pkg::value_t'(s_tdata) : mg_wr_data;
        m1_we    = mg_wr_en && !mg_stat.res_sel;

        src_data_a = mg_stat.res_sel ? m1_rdata_a : m0_rdata_a;
        src_data_b = mg_stat.res_sel ? m1_rdata_b : m0_rdata_b;

        m_tdata = ob_tdata;
        m_tuser = dropped_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            emit_reg    <= '0;
        end else begin
            case (state_reg)
                ST_LOAD: begin
                    if (s_accept) begin
                        count_reg <= count_next;
                        if (!has_room) begin
                            dropped_reg <= 1'b1;
                        end
                        if (s_tlast) begin
                            state_reg <= ST_SORT;
                        end
                    end
                end
                ST_SORT: begin
                    emit_reg <= '0;
                    if (mg_stat.done) begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (emit_issue) begin
                        emit_reg <= emit_reg + 1'b1;
                    end
                    if ((emit_reg == count_reg) && ob_empty) begin
                        count_reg   <= '0;
                        dropped_reg <= 1'b0;
                        state_reg   <= ST_LOAD;
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    msort_ram #(
        .WIDTH (msort_pkg::DATA_W),
        .DEPTH (MAX_COUNT)
    ) u_mem0 (
        .clk     (aclk),
        .we      (m0_we),
        .waddr   (m0_waddr),
        .wdata   (m0_wdata),
        .raddr_a (rd_addr_a),
        .raddr_b (rd_addr_b),
        .rdata_a (m0_rdata_a),
        .rdata_b (m0_rdata_b)
    );

    msort_ram #(
        .WIDTH (msort_pkg::DATA_W),
        .DEPTH (MAX_COUNT)
    ) u_mem1 (
        .clk     (aclk),
        .we      (m1_we),
        .waddr   (mg_wr_addr),
        .wdata   (mg_wr_data),
        .raddr_a (rd_addr_a),
        .raddr_b (rd_addr_b),
        .rdata_a (m1_rdata_a),
        .rdata_b (m1_rdata_b)
    );

    msort_merge #(
        .MAX_COUNT (MAX_COUNT)
    ) u_merge (
        .clk       (aclk),
        .rstn      (aresetn),
        .start     (s_accept && s_tlast),
        .n_in      (count_next),
        .rd_addr_a (mg_rd_addr_a),
        .rd_addr_b (mg_rd_addr_b),
        .rd_data_a (src_data_a),
        .rd_data_b (src_data_b),
        .wr_en     (mg_wr_en),
        .wr_addr   (mg_wr_addr),
        .wr_data   (mg_wr_data),
        .stat      (mg_stat)
    );

    msort_obuf u_obuf (
        .clk        (aclk),
        .rstn       (aresetn),
        .issue      (emit_issue),
        .issue_last (emit_last),
        .rd_data    (src_data_a),
        .room       (ob_room),
        .empty      (ob_empty),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (ob_tdata),
        .m_tlast    (m_tlast)
    );

    `MSC_ASSERT_NOW(a_no_load_while_emit, s_tready, !m_tvalid, "input ready while results pending")
    `MSC_ASSERT_NXT(a_stop_after_last, s_accept && s_tlast, !s_tready, "input ready after last transaction")
    `MSC_ASSERT_NOW(a_count_bound, state_reg != ST_LOAD, count_reg != '0, "empty set sorted or emitted")

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Testbench for merge_sorter_core: loads signed sets over the input stream, checks sorted output.
// Depends on msort_pkg and the merge_sorter_core RTL; self-contained otherwise.
module tb;

    localparam int CAPACITY = 64;

    typedef struct {
        msort_pkg::value_t val;
        logic              last;
        logic              ovf;
    } sorted_item_t;

    typedef struct {
        msort_pkg::value_t val;
        bit                last;
        bit                typed;
        msort_pkg::value_t exp_val;
        bit                exp_ovf;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [31:0] value
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [31:0] sorted_value
    logic        m_tlast;
    logic        m_tuser;   // [0] overflow

    sorted_item_t      pending_sorted[$];
    msort_pkg::value_t set_values[$];
    bit                set_dropped;
    bit                calm;
    int                errors = 0;
    int                accepted;
    int                results_taken = 0;

    stim_row_t directed [22];

    merge_sorter_core #(
        .MAX_COUNT(CAPACITY)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    always #5 aclk = ~aclk;

    // sorter model: stores up to CAPACITY values, queues them in ascending order on tlast unless quiet
    task automatic collect_value(input msort_pkg::value_t v, input bit last, input bit quiet);
        msort_pkg::value_t ordered[$];
        msort_pkg::value_t key;
        int                j;
        sorted_item_t      item;
        if (set_values.size() < CAPACITY)
            set_values.push_back(v);
        else
            set_dropped = 1'b1;
        if (last) begin
            ordered = set_values;
            for (int i = 1; i < ordered.size(); i++) begin
                key = ordered[i];
                j = i - 1;
                while (j >= 0 && ordered[j] > key) begin
                    ordered[j + 1] = ordered[j];
                    j--;
                end
                ordered[j + 1] = key;
            end
            if (!quiet) begin
                for (int k = 0; k < ordered.size(); k++) begin
                    item.val  = ordered[k];
                    item.last = (k == ordered.size() - 1);
                    item.ovf  = set_dropped;
                    pending_sorted.push_back(item);
                end
            end
            set_values.delete();
            set_dropped = 1'b0;
        end
    endtask

    task automatic send_value(input msort_pkg::value_t v, input bit last, input bit typed,
                              input msort_pkg::value_t exp_v, input bit exp_ovf);
        sorted_item_t item;
        while (!calm && $urandom_range(0, 99) < 20) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        accepted++;
        collect_value(v, last, typed);
        if (typed) begin
            item.val  = exp_v;
            item.last = 1'b1;
            item.ovf  = exp_ovf;
            pending_sorted.push_back(item);
        end
        @(negedge aclk);
    endtask

    function automatic msort_pkg::value_t draw_value();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: begin
                case ($urandom_range(0, 3))
                    0:       return 32'sh8000_0000;
                    1:       return 32'sh7FFF_FFFF;
                    2:       return '0;
                    default: return 32'shFFFF_FFFF;
                endcase
            end
            1, 2, 3: return msort_pkg::value_t'($urandom_range(0, 16)) - msort_pkg::value_t'(8);
            default: return msort_pkg::value_t'($urandom());
        endcase
    endfunction

    always @(posedge aclk) begin
        sorted_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_taken++;
            if (pending_sorted.size() == 0) begin
                errors++;
                $display("%0t: unexpected transaction: value %0d last %0b overflow %0b",
                         $time, msort_pkg::value_t'(m_tdata), m_tlast, m_tuser);
            end else begin
                want = pending_sorted.pop_front();
                if (msort_pkg::value_t'(m_tdata) !== want.val || m_tlast !== want.last
                        || m_tuser !== want.ovf) begin
                    errors++;
                    $display("%0t: mismatch: expected %0d/%0b/%0b actual %0d/%0b/%0b",
                             $time, want.val, want.last, want.ovf,
                             msort_pkg::value_t'(m_tdata), m_tlast, m_tuser);
                end
            end
        end
    end

    // receiver: random backpressure plus one long hold-off
    initial begin
        int  hold_cnt;
        bit  hold_done;
        hold_cnt  = 0;
        hold_done = 1'b0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (!hold_done && results_taken >= 150) begin
                hold_done = 1'b1;
                hold_cnt  = 400;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(0, 99) >= 20);
            end
        end
    end

    initial begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        int set_idx;
        int set_len;
        int r;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        calm          = 1'b0;
        set_dropped   = 1'b0;
        accepted      = 0;

        directed = '{
            // single-value sets: the value comes straight back, marked last; then a two-value set of the extremes
            '{32'sh8000_0000, 1'b1, 1'b1, 32'sh8000_0000, 1'b0},
            '{32'sh7FFF_FFFF, 1'b1, 1'b1, 32'sh7FFF_FFFF, 1'b0},
            '{32'sh0000_0000, 1'b1, 1'b1, 32'sh0000_0000, 1'b0},
            '{32'shFFFF_FFFF, 1'b1, 1'b1, 32'shFFFF_FFFF, 1'b0},
            '{32'sh7FFF_FFFF, 1'b0, 1'b0, '0, 1'b0},
            '{32'sh8000_0000, 1'b1, 1'b0, '0, 1'b0},
            // ties
            '{32'sd5, 1'b0, 1'b0, '0, 1'b0},
            '{32'sd5, 1'b0, 1'b0, '0, 1'b0},
            '{-32'sd5, 1'b0, 1'b0, '0, 1'b0},
            '{32'sd5, 1'b1, 1'b0, '0, 1'b0},
            // reversed order, then a set of extremes and bit patterns
            '{32'sd3, 1'b0, 1'b0, '0, 1'b0},
            '{32'sd2, 1'b0, 1'b0, '0, 1'b0},
            '{32'sd1, 1'b0, 1'b0, '0, 1'b0},
            '{32'sd0, 1'b0, 1'b0, '0, 1'b0},
            '{-32'sd1, 1'b0, 1'b0, '0, 1'b0},
            '{-32'sd2, 1'b1, 1'b0, '0, 1'b0},
            '{32'sh8000_0000, 1'b0, 1'b0, '0, 1'b0},
            '{32'sh7FFF_FFFF, 1'b0, 1'b0, '0, 1'b0},
            '{32'sh5555_5555, 1'b0, 1'b0, '0, 1'b0},
            '{32'shAAAA_AAAA, 1'b0, 1'b0, '0, 1'b0},
            '{32'shFFFF_FFFF, 1'b0, 1'b0, '0, 1'b0},
            '{32'sd1, 1'b1, 1'b0, '0, 1'b0}
        };

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed[i])
            send_value(directed[i].val, directed[i].last, directed[i].typed,
                       directed[i].exp_val, directed[i].exp_ovf);

        // first two sets hit a full store exactly and then overflow it
        set_idx = 0;
        while (accepted < 410) begin
            if (set_idx == 0) begin
                set_len = CAPACITY;
            end else if (set_idx == 1) begin
                set_len = CAPACITY + 2;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60)
                    set_len = $urandom_range(1, 8);
                else if (r < 80)
                    set_len = $urandom_range(9, 32);
                else if (r < 88)
                    set_len = $urandom_range(33, CAPACITY - 1);
                else if (r < 94)
                    set_len = CAPACITY;
                else
                    set_len = $urandom_range(CAPACITY + 1, CAPACITY + 8);
                if (set_len > 410 - accepted)
                    set_len = 410 - accepted;
            end
            calm = (set_idx >= 8 && set_idx < 16);
            if (set_idx == 5) begin
                s_tvalid <= 1'b0;
                do @(negedge aclk); while (pending_sorted.size() != 0);
            end
            for (int k = 0; k < set_len; k++)
                send_value(draw_value(), k == set_len - 1, 1'b0, '0, 1'b0);
            set_idx++;
        end

        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_sorted.size() != 0);
        repeat (100) @(negedge aclk);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
